>>> hw/rtl/cmfuv_pkg.sv
`timescale 1ns / 1ps
package cmfuv_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 16;
    localparam int FACE_BITS      = 3;
    localparam int COORD_BITS     = FRACTION_BITS + 1;
    localparam int NUM_BITS       = COMPONENT_BITS + 1;
    localparam int DIVIDEND_BITS  = NUM_BITS + FRACTION_BITS - 1;

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;
    typedef logic signed [COMPONENT_BITS:0]   t_ext;
    typedef logic        [COMPONENT_BITS-1:0] t_mag;
    typedef logic        [COORD_BITS-1:0]     t_coord;
    typedef logic        [FACE_BITS-1:0]      t_face;

    localparam t_face FACE_POS_X = 3'd0;
    localparam t_face FACE_NEG_X = 3'd1;
    localparam t_face FACE_POS_Y = 3'd2;
    localparam t_face FACE_NEG_Y = 3'd3;
    localparam t_face FACE_POS_Z = 3'd4;
    localparam t_face FACE_NEG_Z = 3'd5;

    // Face selected, components projected onto it
    typedef struct packed {
        t_face face;
        logic  zero;
        t_mag  major;
        t_ext  uc;
        t_ext  vc;
    } t_sel;

    // Divider stage contents: partial remainders and dividend/quotient shifters
    typedef struct packed {
        t_face  face;
        logic   zero;
        t_mag   major;
        t_mag   rem_u;
        t_mag   rem_v;
        t_coord dq_u;
        t_coord dq_v;
    } t_div;

endpackage

>>> hw/rtl/cmfuv_if.sv
`timescale 1ns / 1ps
interface cmfuv_dir_if;
    import cmfuv_pkg::*;

    logic  valid;
    logic  ready;
    t_comp dir_x;
    t_comp dir_y;
    t_comp dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfuv_uv_if;
    import cmfuv_pkg::*;

    logic   valid;
    logic   ready;
    t_face  face;
    t_coord coord_u;
    t_coord coord_v;
    logic   zero_vector;

    modport source (
        output valid, output face, output coord_u, output coord_v, output zero_vector,
        input ready
    );
    modport sink (
        input valid, input face, input coord_u, input coord_v, input zero_vector,
        output ready
    );
endinterface

>>> hw/rtl/cmfuv_divider.sv
`timescale 1ns / 1ps
module cmfuv_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cmfuv_pkg::t_div i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cmfuv_pkg::t_div o_data
);
    import cmfuv_pkg::*;

    // One restoring step: returns {new remainder, quotient bit}
    function automatic logic [COMPONENT_BITS:0] div_step(t_mag rem, logic in_bit, t_mag major);
        logic [COMPONENT_BITS:0] trial;
        logic [COMPONENT_BITS:0] diff;
        logic                    ge;
        trial = {rem, in_bit};
        diff  = trial - {1'b0, major};
        ge    = (trial >= {1'b0, major});
        return {(ge ? diff[COMPONENT_BITS-1:0] : trial[COMPONENT_BITS-1:0]), ge};
    endfunction

    t_div r_stage [COORD_BITS];
    logic r_valid [COORD_BITS];
    t_div n_stage [COORD_BITS];
    t_div w_src   [COORD_BITS];
    logic w_src_v [COORD_BITS];
    logic w_rdy   [COORD_BITS];

    genvar k;
    generate
        for (k = 0; k < COORD_BITS; k++) begin : g_step
            logic [COMPONENT_BITS:0] w_su;
            logic [COMPONENT_BITS:0] w_sv;

            if (k == 0) begin : g_first
                assign w_src[k]   = i_data;
                assign w_src_v[k] = i_valid;
            end else begin : g_next
                assign w_src[k]   = r_stage[k-1];
                assign w_src_v[k] = r_valid[k-1];
            end

            if (k == COORD_BITS - 1) begin : g_last
                assign w_rdy[k] = !r_valid[k] || i_ready;
            end else begin : g_mid
                assign w_rdy[k] = !r_valid[k] || w_rdy[k+1];
            end

            always_comb begin
                w_su = div_step(w_src[k].rem_u, w_src[k].dq_u[COORD_BITS-1], w_src[k].major);
                w_sv = div_step(w_src[k].rem_v, w_src[k].dq_v[COORD_BITS-1], w_src[k].major);
                n_stage[k]       = w_src[k];
                n_stage[k].rem_u = w_su[COMPONENT_BITS:1];
                n_stage[k].rem_v = w_sv[COMPONENT_BITS:1];
                n_stage[k].dq_u  = {w_src[k].dq_u[COORD_BITS-2:0], w_su[0]};
                n_stage[k].dq_v  = {w_src[k].dq_v[COORD_BITS-2:0], w_sv[0]};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_valid[k] <= w_src_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_src_v[k]) begin
                    r_stage[k] <= n_stage[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_valid[COORD_BITS-1];
    assign o_data  = r_stage[COORD_BITS-1];

endmodule

>>> hw/rtl/cube_map_face_uv_select_top.sv
`timescale 1ns / 1ps
// Cube-map face and texture coordinate select. Takes one direction transaction per
// clock unless stalled by the output, returning the face (0 +X .. 5 -Z) with u,v in
// unsigned Q1.16, ties going to Z, then Y, then X. One stage picks the major axis and
// projects, one forms the dividends, and a 17-stage restoring divider (one quotient
// bit per stage, u and v in parallel) produces the coordinates. Every stage has its
// own valid bit and collapses bubbles, so a stall on the output only holds the
// stages that are full. An all-zero vector returns face 5, u = v = 0 and zero_vector.
module cube_map_face_uv_select_top (
    input logic        i_clk,
    input logic        i_rst_n,
    cmfuv_dir_if.sink  i_dir,
    cmfuv_uv_if.source o_uv
);
    import cmfuv_pkg::*;

    t_sel r_s1;
    t_sel n_s1;
    logic r_v1;
    t_div r_s2;
    t_div n_s2;
    logic r_v2;
    logic w_rdy1;
    logic w_rdy2;
    logic w_div_rdy;
    logic w_div_v;
    t_div w_div_out;

    // Stage 1: magnitudes, major axis, projected components
    always_comb begin
        t_ext xe;
        t_ext ye;
        t_ext ze;
        t_ext xn;
        t_ext yn;
        t_ext zn;
        t_mag ax;
        t_mag ay;
        t_mag az;
        xe = t_ext'(i_dir.dir_x);
        ye = t_ext'(i_dir.dir_y);
        ze = t_ext'(i_dir.dir_z);
        xn = -xe;
        yn = -ye;
        zn = -ze;
        ax = xe[COMPONENT_BITS] ? xn[COMPONENT_BITS-1:0] : xe[COMPONENT_BITS-1:0];
        ay = ye[COMPONENT_BITS] ? yn[COMPONENT_BITS-1:0] : ye[COMPONENT_BITS-1:0];
        az = ze[COMPONENT_BITS] ? zn[COMPONENT_BITS-1:0] : ze[COMPONENT_BITS-1:0];
        n_s1.zero = (ax == '0) && (ay == '0) && (az == '0);
        priority if (az >= ax && az >= ay) begin
            n_s1.major = az;
            n_s1.vc    = ye;
            if (!ze[COMPONENT_BITS] && az != '0) begin
                n_s1.face = FACE_POS_Z;
                n_s1.uc   = xe;
            end else begin
                n_s1.face = FACE_NEG_Z;
                n_s1.uc   = xn;
            end
        end else if (ay >= ax) begin
            n_s1.major = ay;
            n_s1.uc    = xe;
            if (!ye[COMPONENT_BITS]) begin
                n_s1.face = FACE_POS_Y;
                n_s1.vc   = zn;
            end else begin
                n_s1.face = FACE_NEG_Y;
                n_s1.vc   = ze;
            end
        end else begin
            n_s1.major = ax;
            n_s1.vc    = ye;
            if (!xe[COMPONENT_BITS]) begin
                n_s1.face = FACE_POS_X;
                n_s1.uc   = zn;
            end else begin
                n_s1.face = FACE_NEG_X;
                n_s1.uc   = ze;
            end
        end
    end

    // Stage 2: shift (c + major) into dividend position and split off the top bits
    always_comb begin
        logic signed [COMPONENT_BITS+1:0] sum_u;
        logic signed [COMPONENT_BITS+1:0] sum_v;
        logic [DIVIDEND_BITS-1:0]         dvd_u;
        logic [DIVIDEND_BITS-1:0]         dvd_v;
        sum_u = {r_s1.uc[COMPONENT_BITS], r_s1.uc} + $signed({2'b00, r_s1.major});
        sum_v = {r_s1.vc[COMPONENT_BITS], r_s1.vc} + $signed({2'b00, r_s1.major});
        dvd_u = {sum_u[NUM_BITS-1:0], {(FRACTION_BITS-1){1'b0}}};
        dvd_v = {sum_v[NUM_BITS-1:0], {(FRACTION_BITS-1){1'b0}}};
        n_s2.face  = r_s1.face;
        n_s2.zero  = r_s1.zero;
        n_s2.major = r_s1.major;
        n_s2.rem_u = t_mag'(dvd_u[DIVIDEND_BITS-1:COORD_BITS]);
        n_s2.rem_v = t_mag'(dvd_v[DIVIDEND_BITS-1:COORD_BITS]);
        n_s2.dq_u  = dvd_u[COORD_BITS-1:0];
        n_s2.dq_v  = dvd_v[COORD_BITS-1:0];
    end

    assign w_rdy2      = !r_v2 || w_div_rdy;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_dir.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_dir.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_dir.valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    cmfuv_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (w_div_rdy),
        .i_data  (r_s2),
        .o_valid (w_div_v),
        .i_ready (o_uv.ready),
        .o_data  (w_div_out)
    );

    // Zero vector: drop the quotient, report zero coordinates
    assign o_uv.valid       = w_div_v;
    assign o_uv.face        = w_div_out.face;
    assign o_uv.zero_vector = w_div_out.zero;
    assign o_uv.coord_u     = w_div_out.zero ? '0 : w_div_out.dq_u;
    assign o_uv.coord_v     = w_div_out.zero ? '0 : w_div_out.dq_v;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cmfuv_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int CALM_ITEMS     = 300;
    localparam int HOLD_AT_ITEM   = 500;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_face  face;
        t_coord coord_u;
        t_coord coord_v;
        logic   zero_vector;
    } face_uv_t;

    class face_uv_scoreboard;
        face_uv_t expected_q[$];
        int       failures;

        function new();
            failures = 0;
        endfunction

        // Largest magnitude picks the axis; Z wins ties over Y, Y over X.
        function face_uv_t project_to_face(t_comp x, t_comp y, t_comp z);
            longint   sx, sy, sz, ax, ay, az, major, uc, vc;
            face_uv_t r;
            sx = x;
            sy = y;
            sz = z;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            az = (sz < 0) ? -sz : sz;
            if (az >= ax && az >= ay) begin
                major = az;
                if (sz > 0) begin
                    r.face = FACE_POS_Z;
                    uc = sx;
                    vc = sy;
                end else begin
                    r.face = FACE_NEG_Z;
                    uc = -sx;
                    vc = sy;
                end
            end else if (ay >= ax) begin
                major = ay;
                if (sy > 0) begin
                    r.face = FACE_POS_Y;
                    uc = sx;
                    vc = -sz;
                end else begin
                    r.face = FACE_NEG_Y;
                    uc = sx;
                    vc = sz;
                end
            end else begin
                major = ax;
                if (sx > 0) begin
                    r.face = FACE_POS_X;
                    uc = -sz;
                    vc = sy;
                end else begin
                    r.face = FACE_NEG_X;
                    uc = sz;
                    vc = sy;
                end
            end
            if (major == 0) begin
                r.coord_u     = '0;
                r.coord_v     = '0;
                r.zero_vector = 1'b1;
            end else begin
                r.coord_u     = t_coord'(((uc + major) << (FRACTION_BITS - 1)) / major);
                r.coord_v     = t_coord'(((vc + major) << (FRACTION_BITS - 1)) / major);
                r.zero_vector = 1'b0;
            end
            return r;
        endfunction

        function void note_direction(t_comp x, t_comp y, t_comp z);
            expected_q.push_back(project_to_face(x, y, z));
        endfunction

        function void check_result(face_uv_t got);
            face_uv_t exp;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: face %0d u %0d v %0d zero %0d",
                             got.face, got.coord_u, got.coord_v, got.zero_vector);
                return;
            end
            exp = expected_q.pop_front();
            if (got.face != exp.face || got.coord_u != exp.coord_u ||
                got.coord_v != exp.coord_v || got.zero_vector != exp.zero_vector) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: expected face %0d u %0d v %0d zero %0d",
                             exp.face, exp.coord_u, exp.coord_v, exp.zero_vector);
                    $display("          got      face %0d u %0d v %0d zero %0d",
                             got.face, got.coord_u, got.coord_v, got.zero_vector);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cmfuv_dir_if dir_if ();
    cmfuv_uv_if  uv_if ();

    cube_map_face_uv_select_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dir   (dir_if),
        .o_uv    (uv_if)
    );

    face_uv_scoreboard sb;
    bit idle_on;
    bit hold_req;
    bit hold_done;
    int stall_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watch both ends; count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (dir_if.valid && dir_if.ready)
                sb.note_direction(dir_if.dir_x, dir_if.dir_y, dir_if.dir_z);
            if (uv_if.valid && uv_if.ready)
                sb.check_result('{uv_if.face, uv_if.coord_u, uv_if.coord_v,
                                  uv_if.zero_vector});
            if ((dir_if.valid && dir_if.ready) || (uv_if.valid && uv_if.ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
        end
    end

    initial begin
        while (stall_count < STALL_LIMIT)
            @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random back-pressure while idle_on is set, plus one long hold-off on request.
    initial begin
        uv_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                uv_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            uv_if.ready <= idle_on ? ($urandom_range(99) >= 28) : 1'b1;
        end
    end

    task automatic send_direction(input t_comp x, input t_comp y, input t_comp z);
        if (idle_on) begin
            while ($urandom_range(99) < 28) begin
                dir_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        dir_if.valid <= 1'b1;
        dir_if.dir_x <= x;
        dir_if.dir_y <= y;
        dir_if.dir_z <= z;
        do @(posedge i_clk); while (!dir_if.ready);
    endtask

    task automatic pick_direction(output t_comp x, output t_comp y, output t_comp z);
        t_comp c[3];
        t_comp v;
        int    rot;
        int    k;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                foreach (c[i]) c[i] = t_comp'($urandom);
            end
            4: begin
                foreach (c[i]) c[i] = t_comp'(int'($urandom_range(8)) - 4);
            end
            5, 6: begin
                // equal magnitudes on two or three axes
                v = t_comp'($urandom);
                c[0] = v;
                c[1] = $urandom_range(1) ? v : -v;
                if ($urandom_range(1))
                    c[2] = $urandom_range(1) ? v : -v;
                else
                    c[2] = t_comp'($urandom) >>> $urandom_range(15);
            end
            7: begin
                c[0] = $urandom_range(1) ? t_comp'(-32768) : t_comp'(32767);
                c[1] = t_comp'($urandom);
                c[2] = $urandom_range(1) ? t_comp'($urandom) : t_comp'(0);
            end
            8: begin
                foreach (c[i]) c[i] = $urandom_range(3) == 0 ? t_comp'($urandom) : t_comp'(0);
            end
            default: begin
                foreach (c[i]) begin
                    k = $urandom_range(15);
                    c[i] = t_comp'($urandom) >>> k;
                end
            end
        endcase
        rot = $urandom_range(2);
        x = c[rot];
        y = c[(rot + 1) % 3];
        z = c[(rot + 2) % 3];
    endtask

    initial begin
        t_comp x, y, z;
        sb = new();
        idle_on     = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        stall_count = 0;
        i_rst_n      = 1'b0;
        dir_if.valid = 1'b0;
        dir_if.dir_x = '0;
        dir_if.dir_y = '0;
        dir_if.dir_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector, each face, extremes and ties
        send_direction(0, 0, 0);
        send_direction(100, 3, -7);
        send_direction(-100, 3, -7);
        send_direction(3, 100, -7);
        send_direction(3, -100, -7);
        send_direction(3, -7, 100);
        send_direction(3, -7, -100);
        send_direction(32767, 32767, 32767);
        send_direction(-32768, -32768, -32768);
        send_direction(-32768, 0, 0);
        send_direction(0, -32768, 32767);
        send_direction(32767, -32768, 0);
        send_direction(5, 5, 5);
        send_direction(5, 5, 0);
        send_direction(-7, 7, 0);
        send_direction(7, 0, -7);
        send_direction(-3, -3, -3);
        send_direction(32767, -32767, -32768);
        send_direction(-32768, 32767, 32767);
        send_direction(1, 0, 0);
        send_direction(0, 0, -1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_ITEMS)
                idle_on = 1'b1;
            if (n == HOLD_AT_ITEM)
                hold_req = 1'b1;
            pick_direction(x, y, z);
            send_direction(x, y, z);
        end
        dir_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cmfuv_pkg.sv
hw/rtl/cmfuv_if.sv
hw/rtl/cmfuv_divider.sv
hw/rtl/cube_map_face_uv_select_top.sv
test/testbench.sv
